FILE: hw/rtl/compressor_cycle_regulator_assert.svh
// Assertion macros for the compressor cycle regulator.
`ifndef COMPRESSOR_CYCLE_REGULATOR_ASSERT_SVH
`define COMPRESSOR_CYCLE_REGULATOR_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define CCR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("compressor_cycle_regulator assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define CCR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compressor_cycle_regulator assertion failed");

`endif

FILE: hw/rtl/ccr_pkg.sv
// Types and constants for the compressor cycle regulator.
package ccr_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned TicksW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    MODE_STARTING = 2'd0,
    MODE_WORKING  = 2'd1,
    MODE_RESTING  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_LEVEL = 3'd0,
    CFG_COUNT_LIMIT  = 3'd1,
    CFG_START_TICKS  = 3'd2,
    CFG_WORK_TICKS   = 3'd3,
    CFG_REST_TICKS   = 3'd4
  } cfg_idx_e;

  localparam logic [LevelW-1:0] TargetLevelRst = 8'd128;
  localparam logic [LevelW-1:0] CountLimitRst  = 8'd10;
  localparam logic [TicksW-1:0] StartTicksRst  = 32'd60;
  localparam logic [TicksW-1:0] WorkTicksRst   = 32'd600;
  localparam logic [TicksW-1:0] RestTicksRst   = 32'd600;

endpackage

FILE: hw/rtl/compressor_cycle_regulator.sv
// Compressor cycle regulator: thermostat with a fixed on time and a minimum off time.
//
// Usage:
//   Each request on the input channel (in_valid_i / in_stall_o / sample_i) is
//   one timer tick carrying an 8-bit temperature sample. Every tick yields
//   exactly one result request on the output channel (out_valid_o /
//   out_stall_i) with the echoed sample, the qualifier count, the mode and the
//   compressor drive after that tick.
//   Path: an accepted tick sits in the input register, is evaluated by one
//   pass of compare/increment/state logic and lands in the result register
//   once that register is free or draining; the result is presented from then on.
//   Throughput: one tick per cycle while out_stall_i stays low; the state
//   update loop (elapsed counter, qualifier and mode registers) sets that figure.
//   Stall: while the result waits under out_stall_i, one more tick is still
//   taken into the input register; only then does in_stall_o rise.
//   Reset: clears both stages, loads the register defaults (target 128,
//   limit 10, start 60, work 600, rest 600) and puts the machine in STARTING
//   with the compressor off, elapsed time and qualifier at zero.
//   Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
//   high, only while the block is idle. Unknown indexes are ignored.
`include "compressor_cycle_regulator_assert.svh"

module compressor_cycle_regulator import ccr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // tick input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [LevelW-1:0]   sample_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelW-1:0]   sample_echo_o,
  output logic [LevelW-1:0]   qualifier_count_o,
  output logic [1:0]          mode_o,
  output logic                compressor_on_o
);

  // Configuration registers
  logic [LevelW-1:0] target_q;
  logic [LevelW-1:0] limit_q;
  logic [TicksW-1:0] start_ticks_q;
  logic [TicksW-1:0] work_ticks_q;
  logic [TicksW-1:0] rest_ticks_q;

  // Input stage
  logic              in_valid_q, in_valid_d;
  logic [LevelW-1:0] sample_q;
  logic              in_accept;

  // Regulator state
  mode_e             mode_q, mode_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;
  logic [LevelW-1:0] qual_q, qual_d;
  logic              drive_q, drive_d;

  // Result stage
  logic              out_valid_q, out_valid_d;
  logic [LevelW-1:0] out_sample_q;
  logic [LevelW-1:0] out_qual_q;
  mode_e             out_mode_q;
  logic              out_drive_q;

  logic              step;
  logic [TicksW-1:0] elapsed_inc;

  // Evaluate the held tick whenever the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  // Stall the input only when a tick is held and cannot move on.
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= TargetLevelRst;
      limit_q       <= CountLimitRst;
      start_ticks_q <= StartTicksRst;
      work_ticks_q  <= WorkTicksRst;
      rest_ticks_q  <= RestTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_LEVEL: target_q      <= cfg_data_i[LevelW-1:0];
        CFG_COUNT_LIMIT:  limit_q       <= cfg_data_i[LevelW-1:0];
        CFG_START_TICKS:  start_ticks_q <= cfg_data_i[TicksW-1:0];
        CFG_WORK_TICKS:   work_ticks_q  <= cfg_data_i[TicksW-1:0];
        CFG_REST_TICKS:   rest_ticks_q  <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_comb begin
    priority if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
  end

  // Tick evaluation: saturating elapsed count, qualifier, then mode decision.
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TicksW'(1);

  always_comb begin
    // qualifier: rise toward the limit on warm samples, fall toward zero else
    qual_d = qual_q;
    if (sample_q >= target_q) begin
      if (qual_q < limit_q) begin
        qual_d = qual_q + LevelW'(1);
      end
    end else if (qual_q != '0) begin
      qual_d = qual_q - LevelW'(1);
    end

    mode_d    = mode_q;
    drive_d   = drive_q;
    elapsed_d = elapsed_inc;
    unique case (mode_q)
      MODE_STARTING: begin
        if (elapsed_inc >= start_ticks_q) begin
          elapsed_d = '0;
          if (qual_d == limit_q) begin
            mode_d  = MODE_RESTING;
            drive_d = 1'b0;
          end else begin
            mode_d  = MODE_WORKING;
            drive_d = 1'b1;
          end
        end
      end
      MODE_WORKING: begin
        if (elapsed_inc >= work_ticks_q) begin
          elapsed_d = '0;
          mode_d    = MODE_RESTING;
          drive_d   = 1'b0;
        end
      end
      MODE_RESTING: begin
        if (elapsed_inc >= rest_ticks_q && qual_d == '0) begin
          elapsed_d = '0;
          mode_d    = MODE_WORKING;
          drive_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Advance state only when a tick is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_STARTING;
      elapsed_q <= '0;
      qual_q    <= '0;
      drive_q   <= 1'b0;
    end else if (step) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      qual_q    <= qual_d;
      drive_q   <= drive_d;
    end
  end

  // Result register: load on each step, drop once taken.
  always_comb begin
    priority if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_sample_q <= sample_q;
      out_qual_q   <= qual_d;
      out_mode_q   <= mode_d;
      out_drive_q  <= drive_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_echo_o     = out_sample_q;
  assign qualifier_count_o = out_qual_q;
  assign mode_o            = out_mode_q;
  assign compressor_on_o   = out_drive_q;

  // The compressor runs exactly while the machine is in WORKING.
  `CCR_ASSERT(a_drive_matches_mode, (mode_q == MODE_WORKING) == drive_q)
  // A mode change restarts the elapsed time.
  `CCR_ASSERT_NEXT(a_mode_change_clears, step && (mode_d != mode_q), elapsed_q == '0)
  // Every evaluated tick leaves a result pending.
  `CCR_ASSERT_NEXT(a_step_gives_result, step, out_valid_q)
  // Counters move only when a tick is evaluated.
  `CCR_ASSERT_NEXT(a_state_holds_idle, !step, $stable(elapsed_q) && $stable(qual_q))

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the compressor cycle regulator.
module tb_top import ccr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 3000;  // cycles without any handshake
  localparam int unsigned LongHold   = 300;   // receiver hold-off length
  localparam int unsigned PhaseTicks = 95;    // ticks per random phase
  localparam int unsigned NumPhases  = 12;

  // One result request as the regulator should report it.
  typedef struct {
    logic [LevelW-1:0] sample;
    logic [LevelW-1:0] count;
    mode_e             mode;
    logic              on;
  } tick_report_t;

  // Tracks the thermostat state per accepted tick and checks the reports.
  class cycle_tracker;
    logic [LevelW-1:0] target;
    logic [LevelW-1:0] limit;
    logic [TicksW-1:0] start_t;
    logic [TicksW-1:0] work_t;
    logic [TicksW-1:0] rest_t;
    mode_e             cur_mode;
    logic [TicksW-1:0] elapsed;
    logic [LevelW-1:0] qual;
    logic              drive;
    tick_report_t      pending_reports[$];
    int unsigned       mismatches;

    function new();
      target     = TargetLevelRst;
      limit      = CountLimitRst;
      start_t    = StartTicksRst;
      work_t     = WorkTicksRst;
      rest_t     = RestTicksRst;
      cur_mode   = MODE_STARTING;
      elapsed    = '0;
      qual       = '0;
      drive      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_TARGET_LEVEL: target  = v[LevelW-1:0];
        CFG_COUNT_LIMIT:  limit   = v[LevelW-1:0];
        CFG_START_TICKS:  start_t = v;
        CFG_WORK_TICKS:   work_t  = v;
        CFG_REST_TICKS:   rest_t  = v;
        default: ;
      endcase
    endfunction

    function void switch_mode(mode_e next);
      cur_mode = next;
      elapsed  = '0;
      if (next == MODE_WORKING) drive = 1'b1;
      else if (next == MODE_RESTING) drive = 1'b0;
    endfunction

    // Advance the thermostat by one tick and queue the report it yields.
    function void take_tick(logic [LevelW-1:0] s);
      tick_report_t r;
      if (elapsed != '1) elapsed++;
      if (s >= target) begin
        if (qual < limit) qual++;
      end else if (qual > 0) begin
        qual--;
      end
      case (cur_mode)
        MODE_STARTING: begin
          if (elapsed >= start_t) begin
            if (qual == limit) switch_mode(MODE_RESTING);
            else switch_mode(MODE_WORKING);
          end
        end
        MODE_WORKING: begin
          if (elapsed >= work_t) switch_mode(MODE_RESTING);
        end
        MODE_RESTING: begin
          if (elapsed >= rest_t && qual == 0) switch_mode(MODE_WORKING);
        end
        default: ;
      endcase
      r.sample = s;
      r.count  = qual;
      r.mode   = cur_mode;
      r.on     = drive;
      pending_reports.push_back(r);
    endfunction

    task flag(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_report(logic [LevelW-1:0] echo, logic [LevelW-1:0] count,
                      logic [1:0] m, logic on);
      tick_report_t e;
      if (pending_reports.size() == 0) begin
        flag("result request with no tick pending");
        return;
      end
      e = pending_reports.pop_front();
      if (echo !== e.sample)
        flag($sformatf("sample_echo %0d, want %0d", echo, e.sample));
      if (count !== e.count)
        flag($sformatf("qualifier_count %0d, want %0d", count, e.count));
      if (m !== e.mode)
        flag($sformatf("mode %0d, want %0d", m, e.mode));
      if (on !== e.on)
        flag($sformatf("compressor_on %0b, want %0b", on, e.on));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [LevelW-1:0]   sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LevelW-1:0]   sample_echo_o;
  logic [LevelW-1:0]   qualifier_count_o;
  logic [1:0]          mode_o;
  logic                compressor_on_o;

  cycle_tracker tracker = new();

  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 67;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  bit          above_run = 1'b0;

  compressor_cycle_regulator u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_echo_o     (sample_echo_o),
    .qualifier_count_o (qualifier_count_o),
    .mode_o            (mode_o),
    .compressor_on_o   (compressor_on_o)
  );

  // 20 ns clock: low half, then high half.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Drive the result stall at the falling edge. A requested long hold-off is
  // counted down here so the sender keeps offering ticks meanwhile.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LongHold - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every result request taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_report(sample_echo_o, qualifier_count_o, mode_o, compressor_on_o);
  end

  // Abort when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one tick, with a random idle gap first; hold the payload until the
  // block takes it. Call and return at a falling edge.
  task automatic send_tick(input logic [LevelW-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_tick(s);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every tick has reported back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tracker.pending_reports.size() != 0);
  endtask

  // Write one register; only call while the block is idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    tracker.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Produce runs of samples on one side of the target so the qualifier
  // swings between empty and full, with some uniform noise mixed in.
  function automatic logic [LevelW-1:0] pick_sample(input logic [LevelW-1:0] lvl);
    if ($urandom_range(15) == 0) above_run = !above_run;
    if ($urandom_range(4) == 0) return LevelW'($urandom_range(255));
    if (above_run || lvl == 0) return LevelW'($urandom_range(255, lvl));
    return LevelW'($urandom_range(int'(lvl) - 1, 0));
  endfunction

  initial begin
    int unsigned       p;
    int unsigned       k;
    logic [LevelW-1:0] lvl;
    logic [LevelW-1:0] lim;
    logic [TicksW-1:0] wt;
    logic [TicksW-1:0] rt;

    // Hold reset, then release it at a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: field extremes and samples around the target.
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h80);
    send_tick(8'h7F);

    // Endless start time with a zero target: stay in starting, qualifier rises.
    drain();
    write_reg(CFG_TARGET_LEVEL, 32'd0);
    write_reg(CFG_COUNT_LIMIT, 32'd255);
    write_reg(CFG_START_TICKS, 32'hFFFF_FFFF);
    write_reg(CFG_WORK_TICKS, 32'd0);
    write_reg(CFG_REST_TICKS, 32'd0);
    send_tick(8'h00);
    send_tick(8'h55);
    send_tick(8'hAA);

    // Qualifier now equals the limit: leave starting straight into resting.
    drain();
    write_reg(CFG_TARGET_LEVEL, 32'd128);
    write_reg(CFG_COUNT_LIMIT, 32'd4);
    write_reg(CFG_START_TICKS, 32'd0);
    write_reg(CFG_WORK_TICKS, 32'd3);
    write_reg(CFG_REST_TICKS, 32'd2);
    send_tick(8'hFF);

    // Lower the limit under the qualifier: it must not rise while above it, only fall; warm samples then refill it.
    drain();
    write_reg(CFG_COUNT_LIMIT, 32'd1);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'd200);
    send_tick(8'd200);
    send_tick(8'd200);

    // Zero limit: qualifier never rises and is full only at zero.
    drain();
    write_reg(CFG_COUNT_LIMIT, 32'd0);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);

    // Random phases: sender mostly busy first, then receiver, then no idling.
    for (p = 0; p < NumPhases; p++) begin
      if (p == 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 15;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case ($urandom_range(5))
        0:       lvl = 8'd0;
        1:       lvl = 8'd255;
        default: lvl = LevelW'($urandom_range(1, 254));
      endcase
      if (p == 7) lvl = 8'd255;
      case ($urandom_range(5))
        0:       lim = 8'd0;
        1:       lim = 8'd1;
        2:       lim = 8'd255;
        default: lim = LevelW'($urandom_range(2, 12));
      endcase
      wt = ($urandom_range(9) == 0) ? 32'd0 : TicksW'($urandom_range(1, 24));
      rt = ($urandom_range(9) == 0) ? 32'd0 : TicksW'($urandom_range(1, 24));
      if (p == 2) wt = 32'hFFFF_FFFF;
      if (p == 5) rt = 32'hFFFF_FFFF;

      drain();
      write_reg(CFG_TARGET_LEVEL, CfgDataW'(lvl));
      write_reg(CFG_COUNT_LIMIT, CfgDataW'(lim));
      write_reg(CFG_START_TICKS, $urandom());
      write_reg(CFG_WORK_TICKS, wt);
      write_reg(CFG_REST_TICKS, rt);

      for (k = 0; k < PhaseTicks; k++) begin
        // Stall the result side for a long stretch so the input backs up.
        if (k == 30 && (p == 1 || p == 9)) long_hold_req = 1'b1;
        // Pause the sender until every tick has reported back.
        if (k == 50 && (p == 6 || p == 10)) drain();
        send_tick(pick_sample(lvl));
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.pending_reports.size() != 0) tracker.flag("ticks left without a result");
    if (tracker.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
